// ----- sv/psgm_pkg.sv -----
// ----------------------------------------------------------------------------
// psgm_pkg : shared types and constants of the PSG sound mixer
// Register indexes, envelope phase codes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package psgm_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MASTER_VOLUME = 3'd0;
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd1;
    localparam logic [2:0] CFG_WIDE_SAMPLES  = 3'd2;
    localparam logic [2:0] CFG_SAMPLE_OFFSET = 3'd3;
    localparam logic [2:0] CFG_PSG_ENABLE    = 3'd4;

    // item kinds
    localparam logic ACT_TIME  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // envelope phase codes
    localparam logic [2:0] ENV_IDLE  = 3'd0;
    localparam logic [2:0] ENV_START = 3'd2;
    localparam logic [2:0] ENV_FALL  = 3'd4;
    localparam logic [2:0] ENV_RISE  = 3'd5;

    // sound register indexes used at fixed places
    localparam logic [3:0] SR_NOISE_PERIOD = 4'd6;
    localparam logic [3:0] SR_MIXER        = 4'd7;
    localparam logic [3:0] SR_ENV_FINE     = 4'd11;
    localparam logic [3:0] SR_ENV_COARSE   = 4'd12;
    localparam logic [3:0] SR_ENV_SHAPE    = 4'd13;

    // reciprocal of 15 scaled by 2^19, exact for products below 4096
    localparam logic [15:0] RECIP_15       = 16'd34953;
    localparam int          RECIP_15_SHIFT = 19;

    localparam logic [9:0]  MIN_PERIOD     = 10'd4;
    localparam logic [11:0] ACC_CEILING    = 12'd2047;

    typedef logic [7:0] byte_t;

endpackage

// ----- sv/psgm_if.sv -----
// ----------------------------------------------------------------------------
// psgm_if : channel interfaces of the PSG sound mixer
// Item, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface psgm_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] elapsed_tstates;
    logic       beeper_bit;
    logic [3:0] reg_address;
    logic [7:0] reg_data;

    modport source (output valid, action, elapsed_tstates, beeper_bit, reg_address,
                    reg_data, input ready);
    modport sink   (input valid, action, elapsed_tstates, beeper_bit, reg_address,
                    reg_data, output ready);
endinterface

interface psgm_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        last_sample;

    modport source (output valid, sample, last_sample, input ready);
    modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface psgm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/psg_tone_envelope_sound_mixer.sv -----
// ----------------------------------------------------------------------------
// psg_tone_envelope_sound_mixer : three-tone PSG with noise, envelope, beeper
// Sound register file, tone and noise generators, envelope and sample mixer
// run by one small sequencer over a tone step unit shared by the tone channels.
// ----------------------------------------------------------------------------
// A register write item is taken in the idle state. A time item runs through
// set-up, the envelope step, one tone tick per TONE_PRESCALE tstates carried
// (each tick steps the three tone channels through the shared step unit and
// then the noise), a check that finds no further tick, the channel volumes
// when any tick occurred (multiply, then reciprocal scale, per channel), the
// mixer sum, then one sample per cycle while the output register is free,
// and a closing step. With the PSG disabled the envelope, tone and volume
// steps are skipped. A time item is held up for as long as the receiver
// holds a sample back. The item channel is ready only between items; the
// last sample of one item may still wait in the output register when the
// next item is taken.
// ----------------------------------------------------------------------------
module psg_tone_envelope_sound_mixer #(
    parameter int MAX_SAMPLES_PER_ITEM = 64,
    parameter int TONE_PRESCALE        = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    psgm_item_if.sink        item,
    psgm_result_if.source    result,
    psgm_cfg_if.sink         cfg
);

    localparam int N_W    = $clog2(MAX_SAMPLES_PER_ITEM + 1);
    localparam int TACC_W = $clog2(TONE_PRESCALE + 256);

    localparam logic [N_W-1:0]    N_MAX  = N_W'(MAX_SAMPLES_PER_ITEM);
    localparam logic [N_W-1:0]    N_LAST = N_W'(MAX_SAMPLES_PER_ITEM - 1);
    localparam logic [TACC_W-1:0] PRESC  = TACC_W'(TONE_PRESCALE);

    localparam int SR_NOISE_PERIOD_IDX = int'(psgm_pkg::SR_NOISE_PERIOD);
    localparam int SR_MIXER_IDX        = int'(psgm_pkg::SR_MIXER);
    localparam int SR_ENV_FINE_IDX     = int'(psgm_pkg::SR_ENV_FINE);
    localparam int SR_ENV_COARSE_IDX   = int'(psgm_pkg::SR_ENV_COARSE);
    localparam int SR_ENV_SHAPE_IDX    = int'(psgm_pkg::SR_ENV_SHAPE);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ENV  = 3'd1;
    localparam logic [2:0] ST_TONE = 3'd2;
    localparam logic [2:0] ST_VOLP = 3'd3;
    localparam logic [2:0] ST_VOLD = 3'd4;
    localparam logic [2:0] ST_MIXP = 3'd5;
    localparam logic [2:0] ST_SAMP = 3'd6;

    logic [2:0]          state_reg, state_next;
    psgm_pkg::byte_t     sr_reg [16];
    psgm_pkg::byte_t     sr_next [16];
    logic [8:0]          env_acc_reg, env_acc_next;
    logic                env_pend_reg, env_pend_next;
    logic [TACC_W-1:0]   tone_acc_reg, tone_acc_next;
    logic [10:0]         tone_cnt_reg [3];
    logic [10:0]         tone_cnt_next [3];
    logic [2:0]          tone_lvl_reg, tone_lvl_next;
    logic [4:0]          noise_cnt_reg, noise_cnt_next;
    logic                noise_lvl_reg, noise_lvl_next;
    logic [15:0]         lfsr_reg, lfsr_next;
    logic [15:0]         env_cnt_reg, env_cnt_next;
    logic [3:0]          env_lvl_reg, env_lvl_next;
    logic [2:0]          env_phase_reg, env_phase_next;
    psgm_pkg::byte_t     vol_reg [3];
    psgm_pkg::byte_t     vol_next [3];
    logic [7:0]          beep_lvl_reg, beep_lvl_next;
    logic [11:0]         samp_acc_reg, samp_acc_next;
    logic [7:0]          mv_reg, mv_next;
    logic [9:0]          sp_reg, sp_next;
    logic                wide_reg, wide_next;
    logic [7:0]          off_reg, off_next;
    logic                psg_en_reg, psg_en_next;
    logic                beep_bit_reg, beep_bit_next;
    logic [1:0]          ch_reg, ch_next;
    logic                ticked_reg, ticked_next;
    logic [11:0]         prod_reg, prod_next;
    logic [10:0]         psg_sum_reg, psg_sum_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic [9:0]          period_reg, period_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_sample_reg, out_sample_next;
    logic                out_last_reg, out_last_next;

    // 16-bit value modulo 3 by folding base-4 digits
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
          + 5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        u = 3'(t[1:0]) + 3'(t[2]);
        return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

    // fixed level or envelope level of one channel
    function automatic logic [3:0] chan_level(input psgm_pkg::byte_t r,
                                              input logic [3:0] env);
        return r[4] ? env : r[3:0];
    endfunction

    assign item.ready    = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign result.valid       = out_valid_reg;
    assign result.sample      = out_sample_reg;
    assign result.last_sample = out_last_reg;

    // next-state logic of the whole sequencer
    always_comb
    begin
        logic [8:0]        env_sum;
        logic [11:0]       cur_period;
        logic [10:0]       cur_cnt;
        logic [10:0]       new_cnt;
        logic              cur_lvl;
        logic              new_lvl;
        logic [4:0]        np;
        logic              fb;
        logic [15:0]       lfsr_new;
        logic [5:0]        nc;
        logic [3:0]        shape;
        logic signed [5:0] lvl;
        logic [2:0]        ph;
        psgm_pkg::byte_t   vreg;
        logic [27:0]       scaled;
        logic [6:0]        step;
        logic [8:0]        b_up;
        logic [7:0]        beep_new;
        logic [11:0]       value;
        logic [7:0]        sbyte;
        logic [11:0]       acc_after;
        psgm_pkg::byte_t   mix;

        state_next      = state_reg;
        sr_next         = sr_reg;
        env_acc_next    = env_acc_reg;
        env_pend_next   = env_pend_reg;
        tone_acc_next   = tone_acc_reg;
        tone_cnt_next   = tone_cnt_reg;
        tone_lvl_next   = tone_lvl_reg;
        noise_cnt_next  = noise_cnt_reg;
        noise_lvl_next  = noise_lvl_reg;
        lfsr_next       = lfsr_reg;
        env_cnt_next    = env_cnt_reg;
        env_lvl_next    = env_lvl_reg;
        env_phase_next  = env_phase_reg;
        vol_next        = vol_reg;
        beep_lvl_next   = beep_lvl_reg;
        samp_acc_next   = samp_acc_reg;
        mv_next         = mv_reg;
        sp_next         = sp_reg;
        wide_next       = wide_reg;
        off_next        = off_reg;
        psg_en_next     = psg_en_reg;
        beep_bit_next   = beep_bit_reg;
        ch_next         = ch_reg;
        ticked_next     = ticked_reg;
        prod_next       = prod_reg;
        psg_sum_next    = psg_sum_reg;
        n_next          = n_reg;
        period_next     = period_reg;
        out_valid_next  = out_valid_reg & ~result.ready;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;

        env_sum    = env_acc_reg + 9'(item.elapsed_tstates);
        cur_period = '0;
        cur_cnt    = '0;
        cur_lvl    = 1'b0;
        new_cnt    = '0;
        new_lvl    = 1'b0;
        np         = sr_reg[SR_NOISE_PERIOD_IDX][4:0];
        fb         = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
        lfsr_new   = {fb, lfsr_reg[15:1]};
        nc         = 6'((7'(np) + 7'(mod3_16(lfsr_new))) >> 1);
        shape      = sr_reg[SR_ENV_SHAPE_IDX][3:0];
        lvl        = 6'(signed'({2'b00, env_lvl_reg}));
        ph         = env_phase_reg;
        vreg       = '0;
        scaled     = 28'(prod_reg) * 28'(psgm_pkg::RECIP_15);
        step       = period_reg[9:3];
        b_up       = 9'(beep_lvl_reg) + 9'(step);
        beep_new   = '0;
        value      = '0;
        sbyte      = '0;
        acc_after  = samp_acc_reg - 12'(period_reg);
        mix        = sr_reg[SR_MIXER_IDX];

        // configuration writes
        if (cfg.valid)
        begin
            unique case (cfg.index)
                psgm_pkg::CFG_MASTER_VOLUME: mv_next     = cfg.data[7:0];
                psgm_pkg::CFG_SAMPLE_PERIOD: sp_next     = cfg.data;
                psgm_pkg::CFG_WIDE_SAMPLES:  wide_next   = cfg.data[0];
                psgm_pkg::CFG_SAMPLE_OFFSET: off_next    = cfg.data[7:0];
                psgm_pkg::CFG_PSG_ENABLE:    psg_en_next = cfg.data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            // take an item: write a register, or set up a time advance
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.action == psgm_pkg::ACT_WRITE)
                    begin
                        sr_next[item.reg_address] = item.reg_data;
                        if (item.reg_address == psgm_pkg::SR_ENV_SHAPE)
                        begin
                            env_phase_next = psgm_pkg::ENV_START;
                            env_cnt_next   = '0;
                        end
                    end
                    else
                    begin
                        samp_acc_next = samp_acc_reg + 12'(item.elapsed_tstates);
                        period_next   = (sp_reg < psgm_pkg::MIN_PERIOD) ?
                                        psgm_pkg::MIN_PERIOD : sp_reg;
                        beep_bit_next = item.beeper_bit;
                        ch_next       = '0;
                        ticked_next   = 1'b0;
                        n_next        = '0;
                        if (psg_en_reg)
                        begin
                            env_pend_next = env_sum[8];
                            env_acc_next  = {1'b0, env_sum[7:0]};
                            tone_acc_next = tone_acc_reg + TACC_W'(item.elapsed_tstates);
                            state_next    = ST_ENV;
                        end
                        else
                        begin
                            state_next = ST_MIXP;
                        end
                    end
                end
            end

            // advance the envelope by at most one step
            ST_ENV:
            begin
                if (env_pend_reg)
                begin
                    if (sr_reg[SR_ENV_FINE_IDX] == 8'd0 && sr_reg[SR_ENV_COARSE_IDX] == 8'd0)
                    begin
                        env_lvl_next = 4'd15;
                    end
                    else if (env_cnt_reg != 16'd0)
                    begin
                        env_cnt_next = env_cnt_reg - 16'd1;
                    end
                    else
                    begin
                        env_cnt_next = {sr_reg[SR_ENV_COARSE_IDX], sr_reg[SR_ENV_FINE_IDX]};
                        if (ph[1])
                        begin
                            if (shape < 4'd4 || (shape >= 4'd8 && shape <= 4'd11))
                            begin
                                ph  = psgm_pkg::ENV_FALL;
                                lvl = 6'sd16;
                            end
                            else
                            begin
                                ph  = psgm_pkg::ENV_RISE;
                                lvl = -6'sd1;
                            end
                        end
                        if (ph[2])
                        begin
                            unique case (shape)
                                4'd0, 4'd1, 4'd2, 4'd3, 4'd9:
                                begin
                                    lvl = lvl - 6'sd1;
                                    if (lvl <= 6'sd0)
                                    begin
                                        lvl = 6'sd0;
                                        ph  = psgm_pkg::ENV_IDLE;
                                    end
                                end
                                4'd4, 4'd5, 4'd6, 4'd7, 4'd15:
                                begin
                                    lvl = lvl + 6'sd1;
                                    if (lvl >= 6'sd16)
                                    begin
                                        lvl = 6'sd0;
                                        ph  = psgm_pkg::ENV_IDLE;
                                    end
                                end
                                4'd8:
                                begin
                                    lvl = lvl - 6'sd1;
                                    if (lvl < 6'sd0)
                                        lvl = 6'sd15;
                                end
                                4'd10, 4'd14:
                                begin
                                    if (ph[0])
                                        lvl = lvl + 6'sd1;
                                    else
                                        lvl = lvl - 6'sd1;
                                    if (lvl >= 6'sd16)
                                    begin
                                        lvl = 6'sd14;
                                        ph  = psgm_pkg::ENV_FALL;
                                    end
                                    if (lvl < 6'sd0)
                                    begin
                                        lvl = 6'sd1;
                                        ph  = psgm_pkg::ENV_RISE;
                                    end
                                end
                                4'd11:
                                begin
                                    lvl = lvl - 6'sd1;
                                    if (lvl < 6'sd0)
                                    begin
                                        lvl = 6'sd15;
                                        ph  = psgm_pkg::ENV_IDLE;
                                    end
                                end
                                4'd12:
                                begin
                                    lvl = lvl + 6'sd1;
                                    if (lvl >= 6'sd16)
                                        lvl = 6'sd0;
                                end
                                4'd13:
                                begin
                                    lvl = lvl + 6'sd1;
                                    if (lvl >= 6'sd15)
                                    begin
                                        lvl = 6'sd15;
                                        ph  = psgm_pkg::ENV_IDLE;
                                    end
                                end
                            endcase
                        end
                        if (lvl < 6'sd0)
                            lvl = 6'sd0;
                        if (lvl > 6'sd15)
                            lvl = 6'sd15;
                        env_lvl_next   = lvl[3:0];
                        env_phase_next = ph;
                    end
                end
                env_pend_next = 1'b0;
                state_next    = ST_TONE;
            end

            // one tone channel or the noise generator per cycle
            ST_TONE:
            begin
                unique case (ch_reg)
                    2'd0:
                    begin
                        cur_period = {sr_reg[1][3:0], sr_reg[0]};
                        cur_cnt    = tone_cnt_reg[0];
                        cur_lvl    = tone_lvl_reg[0];
                    end
                    2'd1:
                    begin
                        cur_period = {sr_reg[3][3:0], sr_reg[2]};
                        cur_cnt    = tone_cnt_reg[1];
                        cur_lvl    = tone_lvl_reg[1];
                    end
                    2'd2:
                    begin
                        cur_period = {sr_reg[5][3:0], sr_reg[4]};
                        cur_cnt    = tone_cnt_reg[2];
                        cur_lvl    = tone_lvl_reg[2];
                    end
                    default: ;
                endcase

                // shared tone step: count down, toggle and reload at zero; a zero period keeps the level low
                if (cur_period == 12'd0)
                begin
                    new_cnt = cur_cnt;
                    new_lvl = 1'b0;
                end
                else if (cur_cnt != 11'd0)
                begin
                    new_cnt = cur_cnt - 11'd1;
                    new_lvl = cur_lvl;
                end
                else
                begin
                    new_cnt = cur_period[11:1];
                    new_lvl = ~cur_lvl;
                end

                if (ch_reg == 2'd0 && tone_acc_reg < PRESC)
                begin
                    ch_next    = '0;
                    state_next = ticked_reg ? ST_VOLP : ST_MIXP;
                end
                else
                begin
                    unique case (ch_reg)
                        2'd0:
                        begin
                            tone_acc_next    = tone_acc_reg - PRESC;
                            ticked_next      = 1'b1;
                            tone_cnt_next[0] = new_cnt;
                            tone_lvl_next[0] = new_lvl;
                            ch_next          = 2'd1;
                        end
                        2'd1:
                        begin
                            tone_cnt_next[1] = new_cnt;
                            tone_lvl_next[1] = new_lvl;
                            ch_next          = 2'd2;
                        end
                        2'd2:
                        begin
                            tone_cnt_next[2] = new_cnt;
                            tone_lvl_next[2] = new_lvl;
                            ch_next          = 2'd3;
                        end
                        default:
                        begin
                            // noise: reload from the LFSR with jitter
                            if (np == 5'd0)
                            begin
                                noise_lvl_next = 1'b0;
                            end
                            else if (noise_cnt_reg != 5'd0)
                            begin
                                noise_cnt_next = noise_cnt_reg - 5'd1;
                            end
                            else
                            begin
                                lfsr_next      = lfsr_new;
                                noise_lvl_next = ~noise_lvl_reg;
                                noise_cnt_next = (nc > 6'd16) ? 5'd16 : nc[4:0];
                            end
                            ch_next = 2'd0;
                        end
                    endcase
                end
            end

            // channel volume, step one: level times full scale
            ST_VOLP:
            begin
                unique case (ch_reg)
                    2'd0:    vreg = sr_reg[8];
                    2'd1:    vreg = sr_reg[9];
                    default: vreg = sr_reg[10];
                endcase
                prod_next  = 12'(chan_level(vreg, env_lvl_reg)) * 12'(mv_reg);
                state_next = ST_VOLD;
            end

            // channel volume, step two: divide by fifteen
            ST_VOLD:
            begin
                unique case (ch_reg)
                    2'd0:    vol_next[0] = scaled[psgm_pkg::RECIP_15_SHIFT +: 8];
                    2'd1:    vol_next[1] = scaled[psgm_pkg::RECIP_15_SHIFT +: 8];
                    default: vol_next[2] = scaled[psgm_pkg::RECIP_15_SHIFT +: 8];
                endcase
                if (ch_reg == 2'd2)
                begin
                    ch_next    = '0;
                    state_next = ST_MIXP;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_VOLP;
                end
            end

            // sum the enabled tone and noise contributions once per item
            ST_MIXP:
            begin
                psg_sum_next = '0;
                if (psg_en_reg)
                begin
                    psg_sum_next =
                          ((tone_lvl_reg[0] && !mix[0]) ? 11'(vol_reg[0]) : 11'd0)
                        + ((tone_lvl_reg[1] && !mix[1]) ? 11'(vol_reg[1]) : 11'd0)
                        + ((tone_lvl_reg[2] && !mix[2]) ? 11'(vol_reg[2]) : 11'd0)
                        + ((noise_lvl_reg && !mix[3]) ? 11'(vol_reg[0]) : 11'd0)
                        + ((noise_lvl_reg && !mix[4]) ? 11'(vol_reg[1]) : 11'd0)
                        + ((noise_lvl_reg && !mix[5]) ? 11'(vol_reg[2]) : 11'd0);
                end
                state_next = ST_SAMP;
            end

            // emit one sample per cycle while the output register is free
            ST_SAMP:
            begin
                if (samp_acc_reg >= 12'(period_reg) && n_reg < N_MAX)
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        if (beep_bit_reg)
                            beep_new = (b_up > 9'(mv_reg)) ? mv_reg : b_up[7:0];
                        else
                            beep_new = (beep_lvl_reg >= 8'(step)) ?
                                       (beep_lvl_reg - 8'(step)) : 8'd0;
                        value           = 12'(beep_new) + 12'(psg_sum_reg);
                        sbyte           = ((value > 12'd255) ? 8'd255 : value[7:0]) - off_reg;
                        beep_lvl_next   = beep_new;
                        out_sample_next = wide_reg ? {sbyte, 8'h00} : {8'h00, sbyte};
                        out_last_next   = (acc_after < 12'(period_reg)) || (n_reg == N_LAST);
                        out_valid_next  = 1'b1;
                        samp_acc_next   = acc_after;
                        n_next          = n_reg + N_W'(1);
                    end
                end
                else
                begin
                    samp_acc_next = (samp_acc_reg > psgm_pkg::ACC_CEILING) ?
                                    psgm_pkg::ACC_CEILING : samp_acc_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // hold all state that has a reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 16; i++)
                sr_reg[i] <= '0;
            env_acc_reg   <= '0;
            env_pend_reg  <= 1'b0;
            tone_acc_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                tone_cnt_reg[i] <= '0;
                vol_reg[i]      <= '0;
            end
            tone_lvl_reg  <= '0;
            noise_cnt_reg <= '0;
            noise_lvl_reg <= 1'b0;
            lfsr_reg      <= 16'd1;
            env_cnt_reg   <= '0;
            env_lvl_reg   <= 4'd15;
            env_phase_reg <= psgm_pkg::ENV_IDLE;
            beep_lvl_reg  <= '0;
            samp_acc_reg  <= '0;
            mv_reg        <= 8'd128;
            sp_reg        <= 10'd79;
            wide_reg      <= 1'b0;
            off_reg       <= 8'd128;
            psg_en_reg    <= 1'b1;
            beep_bit_reg  <= 1'b0;
            ch_reg        <= '0;
            ticked_reg    <= 1'b0;
            n_reg         <= '0;
            period_reg    <= psgm_pkg::MIN_PERIOD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sr_reg        <= sr_next;
            env_acc_reg   <= env_acc_next;
            env_pend_reg  <= env_pend_next;
            tone_acc_reg  <= tone_acc_next;
            tone_cnt_reg  <= tone_cnt_next;
            vol_reg       <= vol_next;
            tone_lvl_reg  <= tone_lvl_next;
            noise_cnt_reg <= noise_cnt_next;
            noise_lvl_reg <= noise_lvl_next;
            lfsr_reg      <= lfsr_next;
            env_cnt_reg   <= env_cnt_next;
            env_lvl_reg   <= env_lvl_next;
            env_phase_reg <= env_phase_next;
            beep_lvl_reg  <= beep_lvl_next;
            samp_acc_reg  <= samp_acc_next;
            mv_reg        <= mv_next;
            sp_reg        <= sp_next;
            wide_reg      <= wide_next;
            off_reg       <= off_next;
            psg_en_reg    <= psg_en_next;
            beep_bit_reg  <= beep_bit_next;
            ch_reg        <= ch_next;
            ticked_reg    <= ticked_next;
            n_reg         <= n_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        psg_sum_reg    <= psg_sum_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    // sample time left over between items stays within its ceiling
    a_acc_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (samp_acc_reg <= psgm_pkg::ACC_CEILING))
        else $error("sample time accumulator above ceiling between items");

    // tone prescaler is fully drained between items
    a_tone_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (tone_acc_reg < PRESC))
        else $error("tone prescaler not drained");

    // never more samples than the cap for one item
    a_sample_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_MAX)
        else $error("sample count beyond cap");

    // a new sample is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(out_sample_reg)))
        else $error("pending sample overwritten");

endmodule

// ----- verif/psgm_checker.sv -----
// ----------------------------------------------------------------------------
// psgm_checker : sample predictor and scoreboard for the PSG sound mixer
// Watches the item, result and configuration channels, keeps its own copy of
// the sound state, predicts every sample and compares each result transfer.
// ----------------------------------------------------------------------------
module psgm_checker (
    input  logic           clk,
    input  logic           rst_n,
    psgm_item_if           item,
    psgm_result_if         result,
    psgm_cfg_if            cfg,
    output int             fail_count,
    output int             pending
);

    typedef struct packed {
        logic [15:0] sample;
        logic        last_sample;
    } mix_result_t;

    mix_result_t sample_q[$];

    // predictor state
    psgm_pkg::byte_t sregs [16];
    int unsigned tone_acc, env_acc, tone_cnt [3], tone_lvl [3];
    int unsigned noise_cnt, noise_lvl, lfsr, env_cnt, env_lvl, chan_vol [3];
    int unsigned beep_lvl, time_acc;
    logic [2:0]  env_phase;
    int unsigned m_vol, s_period, wide, s_off, psg_on;

    function automatic void restart_state();
        foreach (sregs[i]) sregs[i] = '0;
        tone_acc = 0; env_acc = 0; noise_cnt = 0; noise_lvl = 0; lfsr = 1;
        env_cnt = 0; env_lvl = 15; env_phase = psgm_pkg::ENV_IDLE; beep_lvl = 0;
        time_acc = 0;
        for (int c = 0; c < 3; c++)
        begin
            tone_cnt[c] = 0; tone_lvl[c] = 0; chan_vol[c] = 0;
        end
        m_vol = 128; s_period = 79; wide = 0; s_off = 128; psg_on = 1;
    endfunction

    // advance the envelope by one 256-tstate tick
    function automatic void step_envelope();
        int          lvl;
        int unsigned shape;
        if (sregs[psgm_pkg::SR_ENV_FINE] == 0 && sregs[psgm_pkg::SR_ENV_COARSE] == 0)
        begin
            env_lvl = 15;
            return;
        end
        if (env_cnt != 0)
        begin
            env_cnt--;
            return;
        end
        env_cnt = {sregs[psgm_pkg::SR_ENV_COARSE], sregs[psgm_pkg::SR_ENV_FINE]};
        shape = sregs[psgm_pkg::SR_ENV_SHAPE] & 8'h0F;
        lvl = env_lvl;
        if (env_phase[1])
        begin
            if (shape < 4 || (shape >= 8 && shape <= 11))
            begin
                env_phase = psgm_pkg::ENV_FALL; lvl = 16;
            end
            else
            begin
                env_phase = psgm_pkg::ENV_RISE; lvl = -1;
            end
        end
        if (env_phase[2])
        begin
            case (shape)
                0, 1, 2, 3, 9:
                begin
                    lvl--;
                    if (lvl <= 0) begin lvl = 0; env_phase = psgm_pkg::ENV_IDLE; end
                end
                4, 5, 6, 7, 15:
                begin
                    lvl++;
                    if (lvl >= 16) begin lvl = 0; env_phase = psgm_pkg::ENV_IDLE; end
                end
                8:
                begin
                    lvl--;
                    if (lvl < 0) lvl = 15;
                end
                10, 14:
                begin
                    if (env_phase[0]) lvl++; else lvl--;
                    if (lvl >= 16) begin lvl = 14; env_phase = psgm_pkg::ENV_FALL; end
                    if (lvl < 0) begin lvl = 1; env_phase = psgm_pkg::ENV_RISE; end
                end
                11:
                begin
                    lvl--;
                    if (lvl < 0) begin lvl = 15; env_phase = psgm_pkg::ENV_IDLE; end
                end
                12:
                begin
                    lvl++;
                    if (lvl >= 16) lvl = 0;
                end
                default:
                begin
                    lvl++;
                    if (lvl >= 15) begin lvl = 15; env_phase = psgm_pkg::ENV_IDLE; end
                end
            endcase
        end
        if (lvl < 0) lvl = 0;
        if (lvl > 15) lvl = 15;
        env_lvl = lvl;
    endfunction

    // advance tone and noise generators by one prescaled tick and recompute the channel volumes
    function automatic void step_tones();
        int unsigned per, np, fb, nc, lv;
        for (int c = 0; c < 3; c++)
        begin
            per = {sregs[2*c+1][3:0], sregs[2*c]};
            if (per != 0)
            begin
                if (tone_cnt[c] != 0) tone_cnt[c]--;
                else
                begin
                    tone_lvl[c] ^= 1;
                    tone_cnt[c] = per >> 1;
                end
            end
            else
                tone_lvl[c] = 0;
        end
        np = sregs[psgm_pkg::SR_NOISE_PERIOD] & 8'h1F;
        if (np != 0)
        begin
            if (noise_cnt != 0) noise_cnt--;
            else
            begin
                fb = (lfsr ^ (lfsr >> 2) ^ (lfsr >> 3) ^ (lfsr >> 5)) & 1;
                lfsr = ((lfsr >> 1) | (fb << 15)) & 16'hFFFF;
                noise_lvl ^= 1;
                nc = (np + lfsr % 3) >> 1;
                if (nc > 16) nc = 16;
                noise_cnt = nc;
            end
        end
        else
            noise_lvl = 0;
        for (int c = 0; c < 3; c++)
        begin
            lv = sregs[8+c][4] ? env_lvl : (sregs[8+c] & 8'h0F);
            chan_vol[c] = (lv * m_vol) / 15;
        end
    endfunction

    // work out the samples caused by one time item
    function automatic void predict_samples(input logic [7:0] t, input logic beep);
        int unsigned per, stp, acc, val, mix, b;
        int          n;
        n = 0;
        if (psg_on != 0)
        begin
            env_acc += t;
            if (env_acc > 255)
            begin
                env_acc -= 256;
                step_envelope();
            end
            tone_acc += t;
            while (tone_acc >= 16)
            begin
                tone_acc -= 16;
                step_tones();
            end
        end
        per = (s_period < psgm_pkg::MIN_PERIOD) ? psgm_pkg::MIN_PERIOD : s_period;
        stp = per / 8;
        acc = time_acc + t;
        while (acc >= per && n < 64)
        begin
            acc -= per;
            if (beep)
            begin
                b = beep_lvl + stp;
                if (b > m_vol) b = m_vol;
                beep_lvl = b;
            end
            else
                beep_lvl = (beep_lvl >= stp) ? beep_lvl - stp : 0;
            val = beep_lvl;
            if (psg_on != 0)
            begin
                mix = sregs[psgm_pkg::SR_MIXER];
                if (tone_lvl[0] != 0 && !mix[0]) val += chan_vol[0];
                if (tone_lvl[1] != 0 && !mix[1]) val += chan_vol[1];
                if (tone_lvl[2] != 0 && !mix[2]) val += chan_vol[2];
                if (noise_lvl != 0 && !mix[3]) val += chan_vol[0];
                if (noise_lvl != 0 && !mix[4]) val += chan_vol[1];
                if (noise_lvl != 0 && !mix[5]) val += chan_vol[2];
            end
            if (val > 255) val = 255;
            val = (val - s_off) & 8'hFF;
            sample_q.push_back('{sample: 16'(wide ? (val << 8) : val), last_sample: 1'b0});
            n++;
        end
        if (acc > psgm_pkg::ACC_CEILING) acc = psgm_pkg::ACC_CEILING;
        time_acc = acc;
        if (n > 0) sample_q[$].last_sample = 1'b1;
    endfunction

    // track transfers on every channel
    always @(posedge clk or negedge rst_n)
    begin
        mix_result_t exp_r;
        if (!rst_n)
        begin
            restart_state();
            sample_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    psgm_pkg::CFG_MASTER_VOLUME: m_vol    = cfg.data[7:0];
                    psgm_pkg::CFG_SAMPLE_PERIOD: s_period = cfg.data;
                    psgm_pkg::CFG_WIDE_SAMPLES:  wide     = cfg.data[0];
                    psgm_pkg::CFG_SAMPLE_OFFSET: s_off    = cfg.data[7:0];
                    psgm_pkg::CFG_PSG_ENABLE:    psg_on   = cfg.data[0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (sample_q.size() == 0)
                begin
                    $display("%0t: unexpected result sample=%h last=%b", $realtime,
                             result.sample, result.last_sample);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = sample_q.pop_front();
                    if (exp_r.sample !== result.sample
                        || exp_r.last_sample !== result.last_sample)
                    begin
                        $display("%0t: mismatch expected sample=%h last=%b actual sample=%h last=%b",
                                 $realtime, exp_r.sample, exp_r.last_sample,
                                 result.sample, result.last_sample);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                if (item.action == psgm_pkg::ACT_WRITE)
                begin
                    sregs[item.reg_address] = item.reg_data;
                    if (item.reg_address == psgm_pkg::SR_ENV_SHAPE)
                    begin
                        env_phase = psgm_pkg::ENV_START;
                        env_cnt = 0;
                    end
                end
                else
                    predict_samples(item.elapsed_tstates, item.beeper_bit);
            end
        end
        pending = sample_q.size();
    end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench : stimulus and verdict for the PSG sound mixer
// Drives register writes and time items with random gaps and back-pressure
// over several configurations; the checker predicts and compares samples.
// ----------------------------------------------------------------------------
module testbench;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending;
    bit   hold_off = 1'b0;

    psgm_item_if   item ();
    psgm_result_if result ();
    psgm_cfg_if    cfg ();

    psg_tone_envelope_sound_mixer u_dut (
        .clk(clk), .rst_n(rst_n), .item(item), .result(result), .cfg(cfg)
    );

    psgm_checker u_checker (
        .clk(clk), .rst_n(rst_n), .item(item), .result(result), .cfg(cfg),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        item.valid = 1'b0; item.action = psgm_pkg::ACT_TIME; item.elapsed_tstates = '0;
        item.beeper_bit = 1'b0; item.reg_address = '0; item.reg_data = '0;
        cfg.valid = 1'b0; cfg.index = psgm_pkg::CFG_MASTER_VOLUME; cfg.data = '0;
        result.ready = 1'b0;
    end

    // receiver: random stall per transfer, long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 10));
            if (hold_off)
            begin
                // long stall counted here while the sender keeps offering items
                hold_off = 1'b0;
                gap      = 400;
            end
            if (gap != 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
        end
    end

    task automatic write_cfg(input logic [2:0] idx, input logic [9:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic send_item(input logic act, input logic [7:0] t, input logic beep,
                             input logic [3:0] addr, input logic [7:0] data, input bit gaps);
        int gap;
        gap = gaps ? int'($urandom_range(0, 10)) : 0;
        if (gap != 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.action <= act;
        item.elapsed_tstates <= t;
        item.beeper_bit <= beep;
        item.reg_address <= addr;
        item.reg_data <= data;
        do @(posedge clk); while (!item.ready);
    endtask

    task automatic wait_idle();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic rand_item(input bit gaps);
        if ($urandom_range(0, 3) == 0)
            send_item(psgm_pkg::ACT_WRITE, 8'($urandom), 1'($urandom), 4'($urandom),
                      8'($urandom), gaps);
        else
            send_item(psgm_pkg::ACT_TIME, 8'($urandom), 1'($urandom), 4'($urandom),
                      8'($urandom), gaps);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tones, noise, envelope shapes, extremes of the fields
        for (int a = 0; a < 16; a++)
            send_item(psgm_pkg::ACT_WRITE, 8'd0, 1'b0, 4'(a), (a == 7) ? 8'h00 : 8'h03, 1'b1);
        send_item(psgm_pkg::ACT_WRITE, 8'd0, 1'b0, 4'd8, 8'h1F, 1'b1);
        send_item(psgm_pkg::ACT_TIME, 8'hFF, 1'b1, 4'd0, 8'd0, 1'b1);
        send_item(psgm_pkg::ACT_TIME, 8'h00, 1'b0, 4'd0, 8'd0, 1'b1);
        send_item(psgm_pkg::ACT_WRITE, 8'd0, 1'b0, psgm_pkg::SR_ENV_SHAPE, 8'hFF, 1'b1);
        send_item(psgm_pkg::ACT_TIME, 8'hFF, 1'b1, 4'd0, 8'd0, 1'b1);
        send_item(psgm_pkg::ACT_WRITE, 8'd0, 1'b0, psgm_pkg::SR_ENV_COARSE, 8'hFF, 1'b1);
        send_item(psgm_pkg::ACT_WRITE, 8'd0, 1'b0, psgm_pkg::SR_NOISE_PERIOD, 8'hFF, 1'b1);
        send_item(psgm_pkg::ACT_TIME, 8'hFF, 1'b0, 4'd0, 8'd0, 1'b1);
        wait_idle();

        // phases over several settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            write_cfg(psgm_pkg::CFG_MASTER_VOLUME, (ph == 0) ? 10'd255 : (ph == 1) ? 10'd0
                                                   : 10'($urandom_range(0, 255)));
            write_cfg(psgm_pkg::CFG_SAMPLE_PERIOD, (ph == 0) ? 10'd4 : (ph == 1) ? 10'd1023
                                                   : (ph == 2) ? 10'd0
                                                   : 10'($urandom_range(4, 60)));
            write_cfg(psgm_pkg::CFG_WIDE_SAMPLES, 10'(ph[0]));
            write_cfg(psgm_pkg::CFG_SAMPLE_OFFSET, (ph == 0) ? 10'd0 : (ph == 1) ? 10'd255
                                                   : 10'($urandom_range(0, 255)));
            write_cfg(psgm_pkg::CFG_PSG_ENABLE, (ph == 3) ? 10'd0 : 10'd1);
            cfg.valid <= 1'b0;
            for (int k = 0; k < 64; k++)
            begin
                // long receiver hold-off with the sender still offering items
                if (ph == 2 && k == 10) hold_off = 1'b1;
                // sender pause until all results have drained
                if (ph == 4 && k == 20)
                begin
                    item.valid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                rand_item((k % 16) < 10);
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
